// ===== hdl/dnos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnos_pkg
// Shared field widths, codes, controller states and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dnos_pkg;

   localparam int OP_W      = 2;
   localparam int LETTER_W  = 5;
   localparam int RANK_W    = 13;
   localparam int POS_W     = 12;
   localparam int STATUS_W  = 2;
   localparam int REPEAT_W  = 7;

   localparam logic [REPEAT_W-1:0] REPEAT_RESET = 7'd1;

   // operation codes of a request beat
   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // status codes of a response beat
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_MOD,
      ST_RD_DATA,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic append;
      logic scan_start;
      logic scan_run;
      logic mod_start;
      logic mod_step;
      logic res_read;
      logic res_range;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic            clear_last;
      logic [OP_W-1:0] op;
      logic            pos_range;
      logic            mod_done;
      logic            scan_hit;
      logic            scan_end;
   } sts_type;

endpackage

// ===== hdl/dnos_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnos_if
// Valid/ready channels of the store: request, response and register write.
// ----------------------------------------------------------------------------
interface dnos_req_if;
   import dnos_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [LETTER_W-1:0] letter;
   logic [RANK_W-1:0]   rank;
   logic [POS_W-1:0]    position;

   modport source (output valid, output op, output letter, output rank,
                   output position, input ready);
   modport sink   (input valid, input op, input letter, input rank,
                   input position, output ready);
endinterface

interface dnos_rsp_if;
   import dnos_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LETTER_W-1:0] letter_out;
   logic                alive;
   logic [POS_W-1:0]    hit_position;

   modport source (output valid, output status, output letter_out, output alive,
                   output hit_position, input ready);
   modport sink   (input valid, input status, input letter_out, input alive,
                   input hit_position, output ready);
endinterface

interface dnos_csr_if;
   import dnos_pkg::*;
   logic                valid;
   logic                ready;
   logic [REPEAT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/dnos_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnos_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dnos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/dnos_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnos_ctrl
// Sequencer: clearing pass, operation dispatch, modulo walk, scan and
// hand-off to the response register.
// ----------------------------------------------------------------------------
module dnos_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dnos_pkg::sts_type sts,
   output dnos_pkg::cmd_type cmd
);
   import dnos_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.op)
               OP_APPEND: begin
                  cmd.append = 1'b1;
                  state_in   = ST_DONE;
               end
               OP_DELETE: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
               OP_READ: begin
                  if (sts.pos_range) begin
                     cmd.res_range = 1'b1;
                     state_in      = ST_DONE;
                  end else begin
                     cmd.mod_start = 1'b1;
                     state_in      = ST_MOD;
                  end
               end
               default: begin
                  cmd.res_range = 1'b1;
                  state_in      = ST_DONE;
               end
            endcase
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               state_in = ST_RD_DATA;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_RD_DATA: begin
            cmd.res_read = 1'b1;
            state_in     = ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_hit || sts.scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/dnos_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnos_dp
// Datapath: letter and deleted-bit memories, length, modulo and scan
// counters, result and response registers.
// ----------------------------------------------------------------------------
module dnos_dp #(
   parameter int BASE_DEPTH  = 64,
   parameter int TOTAL_DEPTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dnos_pkg::cmd_type               cmd,
   output dnos_pkg::sts_type               sts,
   input  logic                            csr_write,
   input  logic [dnos_pkg::REPEAT_W-1:0]   csr_data,
   input  logic [dnos_pkg::OP_W-1:0]       req_op,
   input  logic [dnos_pkg::LETTER_W-1:0]   req_letter,
   input  logic [dnos_pkg::RANK_W-1:0]     req_rank,
   input  logic [dnos_pkg::POS_W-1:0]      req_position,
   output logic [dnos_pkg::STATUS_W-1:0]   rsp_status,
   output logic [dnos_pkg::LETTER_W-1:0]   rsp_letter_out,
   output logic                            rsp_alive,
   output logic [dnos_pkg::POS_W-1:0]      rsp_hit_position
);
   import dnos_pkg::*;

   localparam int BASE_AW = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
   localparam int LEN_W   = $clog2(BASE_DEPTH + 1);
   localparam int TOT_AW  = (TOTAL_DEPTH > 1) ? $clog2(TOTAL_DEPTH) : 1;
   localparam int TOT_CW  = $clog2(TOTAL_DEPTH + 1);
   localparam int PROD_W  = LEN_W + REPEAT_W;
   localparam int CLAMP_W = (PROD_W > TOT_CW) ? PROD_W : TOT_CW;
   localparam int CMP_W   = (POS_W > TOT_CW) ? POS_W : TOT_CW;
   localparam int MOD_W   = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int RNK_W   = (RANK_W > TOT_CW) ? RANK_W : TOT_CW;

   // configuration and store bookkeeping
   logic [REPEAT_W-1:0] repeat_ff;
   logic [LEN_W-1:0]    base_len_ff;
   logic [TOT_AW-1:0]   clr_ff;
   logic                full;

   // captured request
   logic [OP_W-1:0]     op_ff;
   logic [LETTER_W-1:0] letter_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [TOT_CW-1:0]   len_ff;

   // expanded length
   logic [PROD_W-1:0]   prod;
   logic [TOT_CW-1:0]   len_in;

   // modulo walk and scan
   logic [POS_W-1:0]    rem_ff;
   logic [TOT_CW-1:0]   j_ff;
   logic [BASE_AW-1:0]  b_ff;
   logic [LEN_W-1:0]    b_inc;
   logic [TOT_CW-1:0]   cnt_ff;
   logic [TOT_CW-1:0]   cnt_inc;
   logic                v1_ff;
   logic [TOT_AW-1:0]   j1_ff;
   logic                match;
   logic                hit;
   logic                issue;

   // memory ports
   logic                base_we;
   logic [BASE_AW-1:0]  base_raddr;
   logic [LETTER_W-1:0] base_rdata;
   logic                del_we;
   logic [TOT_AW-1:0]   del_waddr;
   logic [TOT_AW-1:0]   del_raddr;
   logic                del_rdata;

   // result and response registers
   logic [STATUS_W-1:0] res_status_ff;
   logic [LETTER_W-1:0] res_letter_ff;
   logic                res_alive_ff;
   logic [POS_W-1:0]    res_hit_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [LETTER_W-1:0] out_letter_ff;
   logic                out_alive_ff;
   logic [POS_W-1:0]    out_hit_ff;

   assign full = (base_len_ff == LEN_W'(BASE_DEPTH));

   always_comb begin
      prod = PROD_W'(base_len_ff) * PROD_W'(repeat_ff);
      if (CLAMP_W'(prod) > CLAMP_W'(TOTAL_DEPTH)) begin
         len_in = TOT_CW'(TOTAL_DEPTH);
      end else begin
         len_in = TOT_CW'(prod);
      end
   end

   // scan: stage 0 issues (j, b), stage 1 checks the returned letter and bit
   assign cnt_inc = cnt_ff + TOT_CW'(1);
   assign match   = v1_ff && !del_rdata && (base_rdata == letter_ff);
   assign hit     = match && (RNK_W'(cnt_inc) == RNK_W'(rank_ff));
   assign issue   = cmd.scan_run && !hit && (j_ff < len_ff);
   assign b_inc   = LEN_W'(b_ff) + LEN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ff   <= REPEAT_RESET;
         base_len_ff <= '0;
         clr_ff      <= '0;
         v1_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            repeat_ff <= csr_data;
         end
         if (cmd.append && !full) begin
            base_len_ff <= base_len_ff + LEN_W'(1);
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + TOT_AW'(1);
         end
         if (cmd.scan_start) begin
            v1_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            v1_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         letter_ff <= req_letter;
         rank_ff   <= req_rank;
         pos_ff    <= req_position;
         len_ff    <= len_in;
      end
      if (cmd.mod_start) begin
         rem_ff <= pos_ff;
      end else if (cmd.mod_step) begin
         rem_ff <= rem_ff - POS_W'(base_len_ff);
      end
      if (cmd.scan_start) begin
         j_ff   <= '0;
         b_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.scan_run) begin
         if (issue) begin
            j_ff  <= j_ff + TOT_CW'(1);
            j1_ff <= j_ff[TOT_AW-1:0];
            if (b_inc >= base_len_ff) begin
               b_ff <= '0;
            end else begin
               b_ff <= BASE_AW'(b_inc);
            end
         end
         if (match) begin
            cnt_ff <= cnt_inc;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         res_status_ff <= full ? STAT_RANGE : STAT_OK;
         res_letter_ff <= '0;
         res_alive_ff  <= 1'b0;
         res_hit_ff    <= '0;
      end else if (cmd.res_range) begin
         res_status_ff <= STAT_RANGE;
         res_letter_ff <= '0;
         res_alive_ff  <= 1'b0;
         res_hit_ff    <= '0;
      end else if (cmd.scan_start) begin
         res_status_ff <= STAT_OK;
         res_letter_ff <= '0;
         res_alive_ff  <= 1'b0;
         res_hit_ff    <= '0;
      end else if (cmd.res_read) begin
         res_status_ff <= STAT_OK;
         res_letter_ff <= base_rdata;
         res_alive_ff  <= !del_rdata;
         res_hit_ff    <= '0;
      end else if (cmd.scan_run) begin
         if (hit) begin
            res_hit_ff <= POS_W'(j1_ff);
         end else if (sts.scan_end) begin
            res_status_ff <= STAT_NOT_FOUND;
         end
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_letter_ff <= res_letter_ff;
         out_alive_ff  <= res_alive_ff;
         out_hit_ff    <= res_hit_ff;
      end
   end

   // memory addressing
   assign base_we    = cmd.append && !full;
   assign base_raddr = cmd.scan_run ? b_ff : BASE_AW'(rem_ff);
   assign del_we     = cmd.clear_step || (cmd.scan_run && hit);
   assign del_waddr  = cmd.scan_run ? j1_ff : clr_ff;
   assign del_raddr  = cmd.scan_run ? j_ff[TOT_AW-1:0] : TOT_AW'(pos_ff);

   dnos_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (BASE_DEPTH)
   ) u_base_ram (
      .clock (clock),
      .we    (base_we),
      .waddr (base_len_ff[BASE_AW-1:0]),
      .wdata (letter_ff),
      .raddr (base_raddr),
      .rdata (base_rdata)
   );

   dnos_ram #(
      .WIDTH (1),
      .DEPTH (TOTAL_DEPTH)
   ) u_del_ram (
      .clock (clock),
      .we    (del_we),
      .waddr (del_waddr),
      .wdata (cmd.scan_run),
      .raddr (del_raddr),
      .rdata (del_rdata)
   );

   always_comb begin
      sts.clear_last = (clr_ff == TOT_AW'(TOTAL_DEPTH - 1));
      sts.op         = op_ff;
      sts.pos_range  = (CMP_W'(pos_ff) >= CMP_W'(len_ff));
      sts.mod_done   = (MOD_W'(rem_ff) < MOD_W'(base_len_ff));
      sts.scan_hit   = hit;
      sts.scan_end   = !v1_ff && (j_ff >= len_ff);
   end

   assign rsp_status       = out_status_ff;
   assign rsp_letter_out   = out_letter_ff;
   assign rsp_alive        = out_alive_ff;
   assign rsp_hit_position = out_hit_ff;

endmodule

// ===== hdl/delete_nth_occurrence_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delete_nth_occurrence_store_unit
// Repeated-string store that deletes the rank-th alive occurrence of a letter
// and answers position reads.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents                          Accepted when
//  -------  ---  -------------------------------------  ------------------------
//  req      in   op, letter, rank, position             req.valid && req.ready
//  rsp      out  status, letter_out, alive, hit_position rsp.valid && rsp.ready
//  csr      in   data (repeat count)                    csr.valid && csr.ready
//
//  Steps: append, unused op and out-of-range read go from accept through
//  dispatch straight to the done state; an in-range read walks the modulo
//  down (one subtract a cycle) and then reads the letter and deleted bit; a
//  delete runs the one-position-per-cycle scan over the deleted-bit memory
//  read port across the expanded length, up to a hit.
//  Reset: after reset the deleted-bit memory is swept to all alive, one entry
//  a cycle, with req.ready low; csr writes are taken.
//  Stalls: one request is in flight at a time; a finished response waits in
//  the output register, so the next request is taken while rsp is stalled.
//
module delete_nth_occurrence_store_unit #(
   parameter int BASE_DEPTH  = 64,
   parameter int TOTAL_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   dnos_req_if.sink    req,
   dnos_rsp_if.source  rsp,
   dnos_csr_if.sink    csr
);
   import dnos_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register port never stalls; the sender is to write only while nothing
   // is in flight (not enforced); expanded length is sampled at request take
   assign csr.ready = 1'b1;

   // sequencer: owns the handshakes and steps the datapath
   dnos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: memories, counters, result and response registers
   dnos_dp #(
      .BASE_DEPTH  (BASE_DEPTH),
      .TOTAL_DEPTH (TOTAL_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write        (csr.valid && csr.ready),
      .csr_data         (csr.data),
      .req_op           (req.op),
      .req_letter       (req.letter),
      .req_rank         (req.rank),
      .req_position     (req.position),
      .rsp_status       (rsp.status),
      .rsp_letter_out   (rsp.letter_out),
      .rsp_alive        (rsp.alive),
      .rsp_hit_position (rsp.hit_position)
   );

   // no request beat is taken during the clearing pass
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req.ready)
      else $error("request accepted during clearing pass");

   // hold off new beats while one item is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second request accepted while one is in flight");

   // a result handed to the output register shows up as a valid beat
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp.valid)
      else $error("loaded response not presented");

   // at most one start action is raised at once
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.append, cmd.scan_start, cmd.mod_start, cmd.res_range}))
      else $error("more than one operation started at once");

endmodule

// ===== tb/delete_nth_occurrence_store_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delete_nth_occurrence_store_unit_tb
// Self-checking bench for the repeated-string store. A table of directed
// beats covers the empty store, the field extremes, every op code and the
// error paths. Random phases follow, each after a repeat write. Each accepted
// request runs through a behavioral copy of the store; each response beat is
// checked field by field against that copy or a fixed row's own response.
// ----------------------------------------------------------------------------
module delete_nth_occurrence_store_unit_tb;
   import dnos_pkg::*;

   localparam int BASE_DEPTH     = 64;
   localparam int TOTAL_DEPTH    = 4096;
   localparam int WATCHDOG_LIMIT = 20000;  // slowest beat is a full 4096-entry scan
   localparam int TAIL_CYCLES    = 5000;   // covers the worst-case scan after drain
   localparam int NO_CSR         = -1;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [LETTER_W-1:0] letter;
      logic [RANK_W-1:0]   rank;
      logic [POS_W-1:0]    position;
   } store_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LETTER_W-1:0] letter_out;
      logic                alive;
      logic [POS_W-1:0]    hit_position;
   } store_rsp_type;

   // one directed beat; fixed rows carry a hand-written response
   typedef struct packed {
      int                  csr_before;
      logic [OP_W-1:0]     op;
      logic [LETTER_W-1:0] letter;
      logic [RANK_W-1:0]   rank;
      logic [POS_W-1:0]    position;
      bit                  fixed;
      logic [STATUS_W-1:0] status;
      logic [LETTER_W-1:0] letter_out;
      logic                alive;
      logic [POS_W-1:0]    hit_position;
   } dir_row_type;

   localparam int DIR_N = 25;

   dir_row_type dir_rows [DIR_N] = '{
      // empty store: nothing to read, nothing to delete, op 3 rejected
      '{NO_CSR,   OP_READ,    0,    0,    0, 1, STAT_RANGE,     0, 0, 0},
      '{NO_CSR,   OP_DELETE,  0,    1,    0, 1, STAT_NOT_FOUND, 0, 0, 0},
      '{NO_CSR,   OP_UNUSED, 31, 8191, 4095, 1, STAT_RANGE,     0, 0, 0},
      // load a, z, an out-of-alphabet code and d
      '{NO_CSR,   OP_APPEND,  0,    0,    0, 1, STAT_OK,        0, 0, 0},
      '{NO_CSR,   OP_APPEND, 25,    0,    0, 1, STAT_OK,        0, 0, 0},
      '{NO_CSR,   OP_APPEND, 31,    0,    0, 1, STAT_OK,        0, 0, 0},
      '{NO_CSR,   OP_APPEND,  3,    0,    0, 1, STAT_OK,        0, 0, 0},
      '{NO_CSR,   OP_READ,    0,    0,    0, 1, STAT_OK,        0, 1, 0},
      '{NO_CSR,   OP_READ,    0,    0,    4, 1, STAT_RANGE,     0, 0, 0},
      '{NO_CSR,   OP_DELETE, 31,    1,    0, 1, STAT_OK,        0, 0, 2},
      '{NO_CSR,   OP_READ,    0,    0,    2, 1, STAT_OK,       31, 0, 0},
      // only match already gone, rank zero, rank at its maximum
      '{NO_CSR,   OP_DELETE, 31,    1,    0, 1, STAT_NOT_FOUND, 0, 0, 0},
      '{NO_CSR,   OP_DELETE,  0,    0,    0, 1, STAT_NOT_FOUND, 0, 0, 0},
      '{NO_CSR,   OP_DELETE, 25, 8191,    0, 1, STAT_NOT_FOUND, 0, 0, 0},
      // repeat 64: top position still past the end, then deep rows
      '{64,       OP_READ,    0,    0, 4095, 1, STAT_RANGE,     0, 0, 0},
      '{NO_CSR,   OP_READ,    0,    0,  255, 0, STAT_OK,        0, 0, 0},
      '{NO_CSR,   OP_DELETE, 25,   64,    0, 0, STAT_OK,        0, 0, 0},
      // append after deletes: deleted bits stay on their positions
      '{NO_CSR,   OP_APPEND,  7,    0,    0, 0, STAT_OK,        0, 0, 0},
      '{NO_CSR,   OP_READ,    0,    0,    2, 0, STAT_OK,        0, 0, 0},
      '{NO_CSR,   OP_DELETE,  0,    3,    0, 0, STAT_OK,        0, 0, 0},
      '{NO_CSR,   OP_READ,    0,    0,  253, 0, STAT_OK,        0, 0, 0},
      // repeat zero empties the expanded string
      '{0,        OP_READ,    0,    0,    0, 1, STAT_RANGE,     0, 0, 0},
      '{NO_CSR,   OP_DELETE,  7,    1,    0, 1, STAT_NOT_FOUND, 0, 0, 0},
      // repeat at its maximum is used as is
      '{127,      OP_READ,    0,    0,  639, 1, STAT_RANGE,     0, 0, 0},
      '{NO_CSR,   OP_DELETE,  7,  127,    0, 0, STAT_OK,        0, 0, 0}
   };

   logic clock = 1'b0;
   logic reset;

   dnos_req_if req_ch ();
   dnos_rsp_if rsp_ch ();
   dnos_csr_if csr_ch ();

   delete_nth_occurrence_store_unit #(
      .BASE_DEPTH  (BASE_DEPTH),
      .TOTAL_DEPTH (TOTAL_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Behavioral copy of the store: base string, its length, the deleted
   // bits of the expanded string and the repeat count.
   logic [LETTER_W-1:0] model_letters [BASE_DEPTH] = '{default: '0};
   int                  model_len = 0;
   bit                  model_deleted [TOTAL_DEPTH] = '{default: 1'b0};
   int                  model_repeat = int'(REPEAT_RESET);

   store_rsp_type op_replies [$];   // responses owed by the store, oldest first
   store_rsp_type owed;
   int            mismatch_count = 0;
   int            quiet_cycles = 0;
   int            burst_left = 1;
   int            stall_left = 0;
   int            calm_left = 0;

   // expanded length, clipped to the deleted-bit memory
   function automatic int expanded_len();
      int n;
      n = model_len * model_repeat;
      return (n > TOTAL_DEPTH) ? TOTAL_DEPTH : n;
   endfunction

   // Apply one request to the copy and return the response it earns.
   function automatic store_rsp_type run_store_op(input store_req_type beat);
      store_rsp_type r;
      int            len;
      int            cnt;
      int            b;
      r   = '0;
      len = expanded_len();
      case (beat.op)
         OP_APPEND: begin
            if (model_len >= BASE_DEPTH) begin
               r.status = STAT_RANGE;
            end else begin
               model_letters[model_len] = beat.letter;
               model_len++;
            end
         end
         OP_DELETE: begin
            // walk the expanded string, base index wraps with the position
            cnt      = 0;
            b        = 0;
            r.status = STAT_NOT_FOUND;
            for (int j = 0; j < len; j++) begin
               if (!model_deleted[j] && model_letters[b] == beat.letter) begin
                  cnt++;
                  if (cnt == int'(beat.rank)) begin
                     model_deleted[j] = 1'b1;
                     r.hit_position   = POS_W'(j);
                     r.status         = STAT_OK;
                     break;
                  end
               end
               b = (b + 1 >= model_len) ? 0 : b + 1;
            end
         end
         OP_READ: begin
            if (int'(beat.position) >= len) begin
               r.status = STAT_RANGE;
            end else begin
               r.letter_out = model_letters[int'(beat.position) % model_len];
               r.alive      = !model_deleted[beat.position];
            end
         end
         default: r.status = STAT_RANGE;
      endcase
      return r;
   endfunction

   // Drive one request beat, hold it until taken, then book its response.
   // Bursts of random length end in a random gap with valid low.
   task automatic issue_request(input store_req_type beat, input bit fixed,
                                input store_rsp_type typed);
      store_rsp_type outcome;
      int            gap;
      @(negedge clock);
      req_ch.valid    = 1'b1;
      req_ch.op       = beat.op;
      req_ch.letter   = beat.letter;
      req_ch.rank     = beat.rank;
      req_ch.position = beat.position;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      outcome = run_store_op(beat);
      if (fixed) begin
         outcome = typed;
      end
      op_replies.insert(op_replies.size(), outcome);
      burst_left--;
      if (burst_left <= 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         repeat (gap) @(negedge clock) req_ch.valid = 1'b0;
      end
   endtask

   // Hold the sender until every owed response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (op_replies.size() != 0) @(negedge clock);
   endtask

   // Rewrite the repeat count with the store idle.
   task automatic write_repeat(input logic [REPEAT_W-1:0] value);
      wait_drained();
      csr_ch.valid = 1'b1;
      csr_ch.data  = value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      model_repeat = int'(value);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Receiver: short random stalls, broken up by calm stretches of
   // back-to-back ready.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
         if (calm_left > 0) begin
            calm_left--;
         end else if ($urandom_range(0, 31) == 0) begin
            calm_left = $urandom_range(40, 300);
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 12);
         end
      end
   end

   // Response checker: each accepted beat is matched against the oldest
   // owed response, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (op_replies.size() == 0) begin
            $display("%0t: response beat with nothing owed, got status %0d",
                     $time, rsp_ch.status);
            mismatch_count++;
         end else begin
            owed = op_replies.pop_front();
            if (rsp_ch.status !== owed.status) begin
               $display("%0t: status expected %0d got %0d",
                        $time, owed.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.letter_out !== owed.letter_out) begin
               $display("%0t: letter_out expected %0d got %0d",
                        $time, owed.letter_out, rsp_ch.letter_out);
               mismatch_count++;
            end
            if (rsp_ch.alive !== owed.alive) begin
               $display("%0t: alive expected %0d got %0d",
                        $time, owed.alive, rsp_ch.alive);
               mismatch_count++;
            end
            if (rsp_ch.hit_position !== owed.hit_position) begin
               $display("%0t: hit_position expected %0d got %0d",
                        $time, owed.hit_position, rsp_ch.hit_position);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int            i;
      int            p;
      int            k;
      int            r;
      int            n;
      int            pct;
      int            len;
      int            cnt;
      int            b;
      int            rep;
      store_req_type beat;
      store_rsp_type typed;

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_APPEND;
      req_ch.letter   = '0;
      req_ch.rank     = '0;
      req_ch.position = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.data     = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table; the clearing sweep after reset just holds off the
      // first beat through req.ready.
      for (i = 0; i < DIR_N; i++) begin
         if (dir_rows[i].csr_before != NO_CSR) begin
            write_repeat(dir_rows[i].csr_before[REPEAT_W-1:0]);
         end
         beat  = '{dir_rows[i].op, dir_rows[i].letter, dir_rows[i].rank,
                   dir_rows[i].position};
         typed = '{dir_rows[i].status, dir_rows[i].letter_out, dir_rows[i].alive,
                   dir_rows[i].hit_position};
         issue_request(beat, dir_rows[i].fixed, typed);
      end

      // Random phases. The first one is append-heavy at a small repeat so
      // the base string fills up and runs into the full store; later ones
      // sweep the repeat extremes with mostly deletes and reads.
      for (p = 0; p < 7; p++) begin
         case (p)
            0:       rep = 1;
            1:       rep = 64;
            2:       rep = 0;
            3:       rep = 127;
            6:       rep = 64;
            default: rep = $urandom_range(1, 64);
         endcase
         write_repeat(rep[REPEAT_W-1:0]);
         n   = (p == 0) ? 75 : 7;
         pct = (p == 0) ? 90 : 15;
         for (k = 0; k < n; k++) begin
            // start from noise in every field, then shape by op
            beat.letter   = LETTER_W'($urandom_range(0, 31));
            beat.rank     = RANK_W'($urandom_range(0, 8191));
            beat.position = POS_W'($urandom_range(0, 4095));
            len           = expanded_len();
            if ($urandom_range(0, 99) < pct) begin
               beat.op = OP_APPEND;
               if ($urandom_range(0, 7) != 0) beat.letter = LETTER_W'($urandom_range(0, 25));
            end else begin
               r = $urandom_range(0, 99);
               if (r < 50) begin
                  beat.op = OP_DELETE;
                  // mostly a letter that is present and a rank that exists;
                  // a few ranks one past the alive count
                  if (len > 0 && r < 42) begin
                     beat.letter = model_letters[$urandom_range(0, model_len - 1)];
                     cnt = 0;
                     b   = 0;
                     for (int j = 0; j < len; j++) begin
                        if (!model_deleted[j] && model_letters[b] == beat.letter) cnt++;
                        b = (b + 1 >= model_len) ? 0 : b + 1;
                     end
                     beat.rank = (cnt == 0 || r < 4) ? RANK_W'(cnt + 1)
                                                     : RANK_W'($urandom_range(1, cnt));
                  end
               end else if (r < 92) begin
                  beat.op = OP_READ;
                  if (len > 0 && r < 86) beat.position = POS_W'($urandom_range(0, len - 1));
               end else begin
                  beat.op = OP_UNUSED;
               end
            end
            issue_request(beat, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && op_replies.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/dnos_pkg.sv
hdl/dnos_if.sv
hdl/dnos_ram.sv
hdl/dnos_ctrl.sv
hdl/dnos_dp.sv
hdl/delete_nth_occurrence_store_unit.sv
tb/delete_nth_occurrence_store_unit_tb.sv
